@@ sv/prf_pkg.sv @@
// ----------------------------------------------------------------------------
// prf_pkg
// shared types and codes of the pollard rho factor finder
// ----------------------------------------------------------------------------
package prf_pkg;

  // operations of the shared modular unit
  typedef enum logic [1:0] {
    OP_MOD,
    OP_MULMOD,
    OP_ADDMOD
  } op_e;

  localparam logic STATUS_FOUND  = 1'b0;
  localparam logic STATUS_FAILED = 1'b1;

endpackage

@@ sv/prf_modunit.sv @@
// ----------------------------------------------------------------------------
// prf_modunit
// shared bit-serial modular unit: remainder, multiply-mod, add-mod
// ----------------------------------------------------------------------------
module prf_modunit import prf_pkg::*; #(
  parameter int unsigned WordBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  op_e                 op_i,
  input  logic [WordBits-1:0] x_i,
  input  logic [WordBits-1:0] y_i,
  input  logic [WordBits-1:0] n_i,
  output logic                done_o,
  output logic [WordBits-1:0] res_o
);

  localparam int unsigned CntBits = $clog2(WordBits + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  op_e                 op_q, op_d;
  logic [WordBits-1:0] r_q, r_d;
  logic [WordBits-1:0] x_q, x_d;
  logic [WordBits-1:0] y_q, y_d;
  logic [WordBits-1:0] n_q, n_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;

  // r < n assumed; add_mod of r and v (v < n)
  function automatic logic [WordBits-1:0] add_mod(
    input logic [WordBits-1:0] r,
    input logic [WordBits-1:0] v,
    input logic [WordBits-1:0] n
  );
    logic [WordBits-1:0] room;
    room = n - v;
    if (r >= room) return r - room;
    return r + v;
  endfunction

  logic [WordBits:0]   sh;
  logic [WordBits-1:0] red;
  logic [WordBits-1:0] dbl;

  always_comb begin
    // restoring remainder step for OP_MOD
    sh  = {r_q, x_q[WordBits-1]};
    red = (sh >= {1'b0, n_q}) ? WordBits'(sh - {1'b0, n_q}) : sh[WordBits-1:0];
    dbl = add_mod(r_q, r_q, n_q);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    r_d    = r_q;
    x_d    = x_q;
    y_d    = y_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = op_i;
      r_d    = '0;
      x_d    = x_i;
      y_d    = y_i;
      n_d    = n_i;
      cnt_d  = CntBits'(WordBits);
      if (op_i == OP_ADDMOD) begin
        r_d    = add_mod(x_i, y_i, n_i);
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (busy_q) begin
      unique case (op_q)
        OP_MOD: begin
          r_d = red;
          x_d = x_q << 1;
        end
        OP_MULMOD: begin
          r_d = y_q[WordBits-1] ? add_mod(dbl, x_q, n_q) : dbl;
          y_d = y_q << 1;
        end
        default: ;
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MOD;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
    n_q <= n_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

@@ sv/prf_seq.sv @@
// ----------------------------------------------------------------------------
// prf_seq
// sequencer: walker steps, difference and euclid gcd on the shared unit
// ----------------------------------------------------------------------------
module prf_seq import prf_pkg::*; #(
  parameter int unsigned WordBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [WordBits-1:0] modulus_i,
  input  logic [WordBits-1:0] increment_i,
  input  logic [WordBits-1:0] start_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordBits-1:0] factor_o,
  output logic                status_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RED_A, S_RED_S, S_SQ, S_ADD, S_DIFF, S_GCD, S_GCD_WAIT, S_OUT
  } state_e;

  state_e              state_q;
  logic [WordBits-1:0] n_q, a_q, u_q, v_q, gx_q, gy_q, fac_q;
  logic [1:0]          step_q;
  logic                st_q;
  logic                start_q;
  op_e                 op_q;
  logic [WordBits-1:0] ux_q, uy_q;

  logic                done;
  logic [WordBits-1:0] res;
  logic [WordBits-1:0] unit_n;

  // the shared unit reads its modulus from n_q; for gcd it divides by gy_q
  assign unit_n = (state_q == S_GCD_WAIT) ? gy_q : n_q;

  prf_modunit #(.WordBits(WordBits)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .op_i   (op_q),
    .x_i    (ux_q),
    .y_i    (uy_q),
    .n_i    (unit_n),
    .done_o (done),
    .res_o  (res)
  );

  logic in_acc;
  assign in_acc = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
      op_q    <= OP_MOD;
      step_q  <= '0;
      n_q     <= '0;
      a_q     <= '0;
      u_q     <= '0;
      v_q     <= '0;
      gx_q    <= '0;
      gy_q    <= '0;
      fac_q   <= '0;
      st_q    <= STATUS_FOUND;
      ux_q    <= '0;
      uy_q    <= '0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          n_q <= modulus_i;
          if (modulus_i == WordBits'(4)) begin
            fac_q <= WordBits'(2); st_q <= STATUS_FOUND; state_q <= S_OUT;
          end else if (modulus_i < WordBits'(2)) begin
            fac_q <= modulus_i; st_q <= STATUS_FAILED; state_q <= S_OUT;
          end else begin
            ux_q <= increment_i; uy_q <= start_value_i;
            op_q <= OP_MOD; start_q <= 1'b1; state_q <= S_RED_A;
            gx_q <= start_value_i;
          end
        end
        S_RED_A: if (done) begin
          a_q <= res; ux_q <= gx_q; start_q <= 1'b1; state_q <= S_RED_S;
        end
        S_RED_S: if (done) begin
          u_q <= res; v_q <= res; step_q <= 2'd0;
          ux_q <= res; uy_q <= res; op_q <= OP_MULMOD; start_q <= 1'b1;
          state_q <= S_SQ;
        end
        S_SQ: if (done) begin
          ux_q <= res; uy_q <= a_q; op_q <= OP_ADDMOD; start_q <= 1'b1;
          state_q <= S_ADD;
        end
        S_ADD: if (done) begin
          // step 0: slow walker, steps 1 and 2: fast walker
          priority if (step_q == 2'd0) begin
            u_q <= res; ux_q <= v_q; uy_q <= v_q;
            op_q <= OP_MULMOD; start_q <= 1'b1; step_q <= 2'd1; state_q <= S_SQ;
          end else if (step_q == 2'd1) begin
            ux_q <= res; uy_q <= res;
            op_q <= OP_MULMOD; start_q <= 1'b1; step_q <= 2'd2; state_q <= S_SQ;
          end else begin
            v_q <= res; state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          gx_q    <= n_q;
          gy_q    <= (u_q >= v_q) ? u_q - v_q : n_q - (v_q - u_q);
          state_q <= S_GCD;
        end
        S_GCD: begin
          // gcd(d, n) computed as gcd(n, d) with remainders
          if (gy_q == '0) begin
            if (gx_q == WordBits'(1)) begin
              ux_q <= u_q; uy_q <= u_q; op_q <= OP_MULMOD; start_q <= 1'b1;
              step_q <= 2'd0; state_q <= S_SQ;
            end else begin
              fac_q   <= gx_q;
              st_q    <= (gx_q == n_q) ? STATUS_FAILED : STATUS_FOUND;
              state_q <= S_OUT;
            end
          end else begin
            ux_q <= gx_q; op_q <= OP_MOD; start_q <= 1'b1; state_q <= S_GCD_WAIT;
          end
        end
        S_GCD_WAIT: if (done) begin
          gx_q <= gy_q; gy_q <= res; state_q <= S_GCD;
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign factor_o    = fac_q;
  assign status_o    = st_q;

endmodule

@@ sv/pollard_rho_factor_finder_top.sv @@
// ----------------------------------------------------------------------------
// pollard_rho_factor_finder_top
// pollard rho divisor search with floyd cycle detection
// ----------------------------------------------------------------------------
// takes modulus n, increment a and seed s, walks x -> (x*x + a) mod n with a
// slow and a fast walker and returns gcd(u - v mod n, n) once it is not 1.
// status 0 means a proper divisor, 1 means the gcd equals n (retry with new
// a and s); n of 4 answers 2 at once, n below 2 answers n with status 1.
// one item at a time: every modular square is a bit-serial shift-add on one
// shared unit followed by an add-mod on the same unit; a round is three
// squares with their adds, the difference and a euclid gcd with one unit
// remainder per step, and two seed reductions come up front. the round count
// grows with the square root of the smallest prime factor. input stall is
// high from acceptance until the result transfer.
// ----------------------------------------------------------------------------
module pollard_rho_factor_finder_top import prf_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] modulus_i,
  input  logic [WORD_BITS-1:0] increment_i,
  input  logic [WORD_BITS-1:0] start_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] factor_o,
  output logic                 status_o
);

  prf_seq #(.WordBits(WORD_BITS)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .modulus_i    (modulus_i),
    .increment_i  (increment_i),
    .start_value_i(start_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .factor_o     (factor_o),
    .status_o     (status_o)
  );

endmodule

@@ bench/pollard_rho_factor_finder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pollard_rho_factor_finder_top_tb
// self-checking bench for the pollard rho divisor search
// ----------------------------------------------------------------------------
// a table of directed items covers the special moduli and the field extremes,
// then random items are built mostly as a small prime times a random cofactor
// so that every search ends in a few rounds. each result is compared with the
// answer of the oldest job still due, from a local rho/floyd model. both sides
// idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module pollard_rho_factor_finder_top_tb;
  import prf_pkg::*;

  localparam int unsigned W       = 32;
  localparam int          N_DIR   = 20;
  localparam int          N_RAND  = 280;
  localparam int          N_JOBS  = N_DIR + N_RAND;
  localparam int          N_TAIL  = 30;   // last items run without idling
  localparam int          DRAIN   = 200;

  typedef struct packed {
    logic [W-1:0] modulus;
    logic [W-1:0] increment;
    logic [W-1:0] start_value;
  } job_t;

  typedef struct packed {
    logic [W-1:0] factor;
    logic         status;
  } answer_t;

  typedef struct packed {
    logic [W-1:0] modulus;
    logic [W-1:0] increment;
    logic [W-1:0] start_value;
    logic         typed;    // answer written in the table
    logic [W-1:0] factor;
    logic         status;
  } dir_row_t;

  // answers typed in only for cases that need no walk or end with g = n
  dir_row_t dir_tab [N_DIR] = '{
    '{32'd4, 32'd1, 32'd0, 1'b1, 32'd2, STATUS_FOUND},
    '{32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd2, STATUS_FOUND},
    '{32'd0, 32'd1, 32'd0, 1'b1, 32'd0, STATUS_FAILED},
    '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1, STATUS_FAILED},
    '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, STATUS_FAILED},
    '{32'd2, 32'd1, 32'd0, 1'b1, 32'd2, STATUS_FAILED},
    '{32'd3, 32'd1, 32'd2, 1'b1, 32'd3, STATUS_FAILED},
    '{32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd3, STATUS_FAILED},
    '{32'd6, 32'd1, 32'd2, 1'b0, '0, 1'b0},
    '{32'd9, 32'd1, 32'd0, 1'b0, '0, 1'b0},
    '{32'd15, 32'd2, 32'd14, 1'b0, '0, 1'b0},
    '{32'd8051, 32'd1, 32'd2, 1'b0, '0, 1'b0},
    '{32'd10403, 32'd1, 32'd2, 1'b0, '0, 1'b0},
    '{32'hFFFF_FFFF, 32'd1, 32'd2, 1'b0, '0, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFE, 1'b0, '0, 1'b0},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
    '{32'h8000_0000, 32'd1, 32'd0, 1'b0, '0, 1'b0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0, '0, 1'b0},
    '{32'd25, 32'd24, 32'd24, 1'b0, '0, 1'b0},
    '{32'd4, 32'd0, 32'h1234_5678, 1'b1, 32'd2, STATUS_FOUND}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] modulus_i = '0;
  logic [W-1:0] increment_i = '0;
  logic [W-1:0] start_value_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] factor_o;
  logic         status_o;

  job_t    jobs [N_JOBS];
  answer_t answers [N_JOBS];   // precomputed answer per job, same order
  int      n_jobs;
  int      sent_cnt = 0;
  int      recv_cnt = 0;
  int      err_cnt = 0;
  longint  cycle_cnt = 0;
  longint  cycle_limit = 64'd1_000_000_000;
  bit      built = 1'b0;

  pollard_rho_factor_finder_top #(.WORD_BITS(W)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .modulus_i, .increment_i,
    .start_value_i, .out_valid_o, .out_stall_i, .factor_o, .status_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one rho step, x and a already below n
  function automatic logic [63:0] rho_next(logic [63:0] x, logic [63:0] a,
                                           logic [63:0] n);
    logic [63:0] sq;
    sq = (x * x) % n;
    return (sq + a) % n;
  endfunction

  // floyd search; also counts rounds and euclid steps for the time budget
  task automatic search_divisor(input job_t j, output answer_t ans,
                                output longint rounds, output longint steps);
    logic [63:0] n, a, u, v, d, g, y, t;
    n = 64'(j.modulus);
    rounds = 0;
    steps = 0;
    if (n == 64'd4) begin
      ans = '{factor: 32'd2, status: STATUS_FOUND};
    end else if (n < 64'd2) begin
      ans = '{factor: n[W-1:0], status: STATUS_FAILED};
    end else begin
      a = 64'(j.increment) % n;
      u = 64'(j.start_value) % n;
      v = u;
      do begin
        u = rho_next(u, a, n);
        v = rho_next(rho_next(v, a, n), a, n);
        d = (u >= v) ? u - v : n - (v - u);
        g = d;
        y = n;
        while (y != 0) begin
          t = g % y;
          g = y;
          y = t;
          steps++;
        end
        rounds++;
      end while (g == 64'd1);
      ans = '{factor: g[W-1:0], status: (g == n) ? STATUS_FAILED : STATUS_FOUND};
    end
  endtask

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("mismatch result %0d %s: got %0h want %0h", recv_cnt, what, got, want);
    err_cnt++;
  endtask

  // build all jobs and answers up front; the time limit follows from them
  initial begin
    int unsigned primes [12];
    job_t    j;
    answer_t ans;
    longint  rounds, steps, budget;
    int unsigned p, kind;
    primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 47};
    budget = 0;
    for (int i = 0; i < N_DIR; i++) begin
      j = '{dir_tab[i].modulus, dir_tab[i].increment, dir_tab[i].start_value};
      search_divisor(j, ans, rounds, steps);
      if (dir_tab[i].typed)
        ans = '{factor: dir_tab[i].factor, status: dir_tab[i].status};
      jobs[i] = j;
      answers[i] = ans;
      budget += 200 + rounds * (3 * (W + 4) + 2) + steps * (W + 3);
    end
    for (int i = 0; i < N_RAND; i++) begin
      kind = $urandom_range(0, 99);
      p = primes[$urandom_range(0, 11)];
      if (kind < 85) begin
        // well formed: small prime times random cofactor, a and s in range
        j.modulus = p * $urandom_range(1, 32'hFFFF_FFFF / p);
        if (j.modulus < 5) j.modulus = 6;
        j.increment = $urandom_range(1, j.modulus - 3);
        j.start_value = $urandom_range(0, j.modulus - 1);
      end else if (kind < 95) begin
        // raw increment and seed, reduced inside the block
        j.modulus = p * $urandom_range(1, 32'hFFFF_FFFF / p);
        j.increment = $urandom;
        j.start_value = $urandom;
      end else begin
        j.modulus = $urandom_range(0, 12);
        j.increment = $urandom;
        j.start_value = $urandom;
      end
      search_divisor(j, ans, rounds, steps);
      jobs[N_DIR + i] = j;
      answers[N_DIR + i] = ans;
      budget += 200 + rounds * (3 * (W + 4) + 2) + steps * (W + 3);
    end
    n_jobs = N_JOBS;
    cycle_limit = 4 * budget + 20000;
    built = 1'b1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > cycle_limit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // sender: one nonblocking write of valid per edge, payload held while stalled
  int unsigned in_idle = 0;
  always @(posedge clk_i) begin
    if (rst_ni && built && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) begin
        sent_cnt = sent_cnt + 1;
      end
      if (in_idle > 0) begin
        in_idle = in_idle - 1;
        in_valid_i <= 1'b0;
      end else if (sent_cnt < n_jobs && sent_cnt < n_jobs - N_TAIL &&
                   $urandom_range(0, 3) == 0) begin
        // idle burst of random length, this one included
        in_idle = $urandom_range(0, 7);
        in_valid_i <= 1'b0;
      end else if (sent_cnt < n_jobs) begin
        in_valid_i    <= 1'b1;
        modulus_i     <= jobs[sent_cnt].modulus;
        increment_i   <= jobs[sent_cnt].increment;
        start_value_i <= jobs[sent_cnt].start_value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: check each result transfer, then pick the next stall value
  int unsigned out_idle = 0;
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (recv_cnt >= sent_cnt) begin
          $display("result %0d with no pending job", recv_cnt);
          err_cnt++;
        end else begin
          want = answers[recv_cnt];
          if (factor_o !== want.factor) report_mismatch("factor", factor_o, want.factor);
          if (status_o !== want.status)
            report_mismatch("status", W'(status_o), W'(want.status));
        end
        recv_cnt++;
      end
      if (out_idle > 0) begin
        out_idle--;
        out_stall_i <= 1'b1;
      end else if (sent_cnt < n_jobs - N_TAIL && $urandom_range(0, 3) == 0) begin
        out_idle = $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // reset once, then wait for every transfer and a short drain
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (built);
    wait (recv_cnt >= n_jobs);
    repeat (DRAIN) @(posedge clk_i);
    if (err_cnt == 0 && recv_cnt == n_jobs) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
